/* rtl/core/crgd_pkg.sv */
`default_nettype none
package crgd_pkg;

    localparam int DATA_W = 32;
    localparam int CELL_W = 20;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam int CELLS_PER_CLASS_DEF = 4096;
    localparam int INDEX_BITS_DEF      = 24;

    localparam logic [CELL_W-1:0] CELL_SIZE_RST      = 20'd9830;
    localparam logic [DATA_W-1:0] OBSTACLE_RANGE_RST = 32'd196608;
    localparam logic [DATA_W-1:0] FREE_RANGE_RST     = 32'd655360;

    // configuration register indexes
    localparam logic [1:0] CFG_CELL_SIZE      = 2'd0;
    localparam logic [1:0] CFG_OBSTACLE_RANGE = 2'd1;
    localparam logic [1:0] CFG_FREE_RANGE     = 2'd2;

    typedef enum logic [1:0] {
        KIND_OBST = 2'd0,
        KIND_FREE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // one classified point as it travels from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     ob;
        logic                     fr;
        logic                     grp;
        logic                     last;
    } t_pt;

endpackage
`default_nettype wire

/* rtl/core/crgd_front.sv */
`default_nettype none
module crgd_front #(
    parameter int INDEX_BITS = crgd_pkg::INDEX_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_x,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_y,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_z,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_depth,
    input  wire                             i_ob,
    input  wire                             i_fr,
    input  wire                             i_last,
    input  wire  [crgd_pkg::CELL_W-1:0]     i_cell,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_ob_range,
    input  wire  [crgd_pkg::DATA_W-1:0]     i_fr_range,
    output logic                            o_valid,
    input  wire                             i_ready,
    output crgd_pkg::t_pt                   o_pt,
    output logic [2*INDEX_BITS-1:0]         o_key
);

    localparam int DW = crgd_pkg::DATA_W;
    localparam int CW = crgd_pkg::CELL_W;
    localparam logic signed [DW+1:0] IMAX = (34'sd1 <<< (INDEX_BITS - 1)) - 34'sd1;
    localparam logic signed [DW+1:0] IMIN = -IMAX - 34'sd1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_OUT  = 3'b100
    } t_fstate;

    t_fstate                       r_state;
    crgd_pkg::t_pt                 r_pt;
    logic [DW-1:0]                 r_xm, r_ym;
    logic [CW-1:0]                 r_xr, r_yr;
    logic                          r_xn, r_yn;
    logic [CW-1:0]                 r_div;
    logic [crgd_pkg::CNT_W-1:0]    r_cnt;

    logic [CW:0]                   w_xt, w_yt;
    logic                          w_xge, w_yge;

    function automatic logic [INDEX_BITS-1:0] floor_sat(
        input logic [DW-1:0] q,
        input logic          neg,
        input logic          remnz
    );
        logic signed [DW+1:0] v;
        v = neg ? (-$signed({2'b00, q}) - $signed({{(DW+1){1'b0}}, remnz}))
                : $signed({2'b00, q});
        if (v > IMAX) begin
            v = IMAX;
        end else if (v < IMIN) begin
            v = IMIN;
        end
        return v[INDEX_BITS-1:0];
    endfunction

    // one restoring step per cycle for x and y
    assign w_xt  = {r_xr, r_xm[DW-1]};
    assign w_yt  = {r_yr, r_ym[DW-1]};
    assign w_xge = w_xt >= {1'b0, r_div};
    assign w_yge = w_yt >= {1'b0, r_div};

    assign o_ready = r_state == F_IDLE;
    assign o_valid = r_state == F_OUT;
    assign o_pt    = r_pt;
    assign o_key   = r_pt.grp ? {floor_sat(r_xm, r_xn, r_xr != '0),
                                 floor_sat(r_ym, r_yn, r_yr != '0)} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_pt.x    <= i_x;
                        r_pt.y    <= i_y;
                        r_pt.z    <= i_z;
                        r_pt.ob   <= i_ob & (i_depth <= i_ob_range);
                        r_pt.fr   <= i_fr & (i_depth <= i_fr_range);
                        r_pt.grp  <= i_cell != '0;
                        r_pt.last <= i_last;
                        r_xn      <= i_x[DW-1];
                        r_yn      <= i_y[DW-1];
                        r_xm      <= i_x[DW-1] ? DW'(-i_x) : i_x;
                        r_ym      <= i_y[DW-1] ? DW'(-i_y) : i_y;
                        r_xr      <= '0;
                        r_yr      <= '0;
                        r_div     <= i_cell;
                        r_cnt     <= '0;
                        r_state   <= (i_cell != '0) ? F_DIV : F_OUT;
                    end
                end
                F_DIV: begin
                    r_xm  <= {r_xm[DW-2:0], w_xge};
                    r_ym  <= {r_ym[DW-2:0], w_yge};
                    r_xr  <= w_xge ? CW'(w_xt - {1'b0, r_div}) : w_xt[CW-1:0];
                    r_yr  <= w_yge ? CW'(w_yt - {1'b0, r_div}) : w_yt[CW-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == crgd_pkg::CNT_W'(DW - 1)) begin
                        r_state <= F_OUT;
                    end
                end
                F_OUT: begin
                    if (i_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/crgd_fifo.sv */
`default_nettype none
module crgd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wvalid,
    output logic             o_wready,
    input  wire  [WIDTH-1:0] i_wdata,
    output logic             o_rvalid,
    input  wire              i_rready,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_wready = r_cnt != 2'd2;
    assign o_rvalid = r_cnt != 2'd0;
    assign o_rdata  = r_mem[r_rp];
    assign w_push   = i_wvalid & o_wready;
    assign w_pop    = i_rready & o_rvalid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

/* rtl/core/crgd_table.sv */
`default_nettype none
module crgd_table #(
    parameter int CELLS = crgd_pkg::CELLS_PER_CLASS_DEF,
    parameter int KW    = 2 * crgd_pkg::INDEX_BITS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [KW-1:0] i_key,
    input  wire           i_clear,
    output logic          o_busy,
    output logic          o_emit,
    output logic          o_ovf
);

    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CELLS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    typedef enum logic [3:0] {
        T_CLEAR = 4'b0001,
        T_IDLE  = 4'b0010,
        T_READ  = 4'b0100,
        T_CMP   = 4'b1000
    } t_tstate;

    // entry: valid bit on top, key below
    logic [KW:0]   r_mem [CELLS];
    logic [KW:0]   r_rd;
    t_tstate       r_state;
    logic [AW-1:0] r_addr;
    logic [KW-1:0] r_key;
    logic [CW-1:0] r_probes;
    logic          r_emit, r_ovf;

    logic [AW-1:0] w_fold;
    logic [AW-1:0] w_home;
    logic          w_we;
    logic [KW:0]   w_wd;
    logic          w_hit;

    always_comb begin
        w_fold = '0;
        for (int i = 0; i < KW; i++) begin
            w_fold[i % AW] = w_fold[i % AW] ^ i_key[i];
        end
        w_home = ({1'b0, w_fold} >= (AW+1)'(CELLS)) ? AW'({1'b0, w_fold} - (AW+1)'(CELLS))
                                                    : w_fold;
    end

    assign w_hit  = r_rd[KW] && (r_rd[KW-1:0] == r_key);
    assign w_we   = (r_state == T_CLEAR) || ((r_state == T_CMP) && !r_rd[KW]);
    assign w_wd   = (r_state == T_CLEAR) ? '0 : {1'b1, r_key};
    assign o_busy = r_state != T_IDLE;
    assign o_emit = r_emit;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_CLEAR;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                T_CLEAR: begin
                    r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (i_clear) begin
                        r_state <= T_CLEAR;
                        r_addr  <= '0;
                    end else if (i_start) begin
                        r_key    <= i_key;
                        r_addr   <= w_home;
                        r_probes <= '0;
                        r_state  <= T_READ;
                    end
                end
                T_READ: begin
                    r_state <= T_CMP;
                end
                T_CMP: begin
                    priority if (w_hit) begin
                        r_emit  <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_state <= T_IDLE;
                    end else if (!r_rd[KW]) begin
                        r_emit  <= 1'b1;
                        r_ovf   <= 1'b0;
                        r_state <= T_IDLE;
                    end else if (r_probes == CW'(CELLS - 1)) begin
                        // every slot holds another cell: table full
                        r_emit  <= 1'b1;
                        r_ovf   <= 1'b1;
                        r_state <= T_IDLE;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                        r_addr   <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
                        r_state  <= T_READ;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/crgd_back.sv */
`default_nettype none
module crgd_back #(
    parameter int CELLS_PER_CLASS = crgd_pkg::CELLS_PER_CLASS_DEF,
    parameter int INDEX_BITS      = crgd_pkg::INDEX_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  crgd_pkg::t_pt         i_pt,
    input  wire  [2*INDEX_BITS-1:0]     i_key,
    output logic                        o_tvalid,
    input  wire                         i_tready,
    output logic [3*crgd_pkg::DATA_W-1:0] o_tdata,
    output logic [2:0]                  o_tuser,
    output logic                        o_tlast
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_WAIT = 3'b010,
        B_EMIT = 3'b100
    } t_bstate;

    t_bstate         r_state;
    crgd_pkg::t_pt   r_pt;
    logic [2:0]      r_pend;
    logic            r_ovf_ob, r_ovf_fr;
    logic            r_tvalid;
    logic [3*crgd_pkg::DATA_W-1:0] r_tdata;
    logic [2:0]      r_tuser;
    logic            r_tlast;

    logic            w_ob_busy, w_fr_busy, w_ob_emit, w_fr_emit, w_ob_ovf, w_fr_ovf;
    logic            w_busy, w_pop, w_load, w_clear;
    logic [2:0]      w_pend_nx;
    crgd_pkg::t_kind w_kind;
    logic            w_ovf;

    assign w_busy  = w_ob_busy | w_fr_busy;
    assign o_ready = (r_state == B_IDLE) && !w_busy;
    assign w_pop   = o_ready & i_valid;
    assign w_load  = (r_state == B_EMIT) && (r_pend != '0) && (!r_tvalid || i_tready);

    always_comb begin
        priority if (r_pend[0]) begin
            w_kind    = crgd_pkg::KIND_OBST;
            w_ovf     = r_ovf_ob;
            w_pend_nx = {r_pend[2:1], 1'b0};
        end else if (r_pend[1]) begin
            w_kind    = crgd_pkg::KIND_FREE;
            w_ovf     = r_ovf_fr;
            w_pend_nx = {r_pend[2], 2'b00};
        end else begin
            w_kind    = crgd_pkg::KIND_END;
            w_ovf     = 1'b0;
            w_pend_nx = 3'b000;
        end
    end

    // the end marker wipes both tables
    assign w_clear = w_load && (w_kind == crgd_pkg::KIND_END);

    crgd_table #(.CELLS(CELLS_PER_CLASS), .KW(2 * INDEX_BITS)) u_ob_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pop & i_pt.ob & i_pt.grp),
        .i_key   (i_key),
        .i_clear (w_clear),
        .o_busy  (w_ob_busy),
        .o_emit  (w_ob_emit),
        .o_ovf   (w_ob_ovf)
    );

    crgd_table #(.CELLS(CELLS_PER_CLASS), .KW(2 * INDEX_BITS)) u_fr_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pop & i_pt.fr & i_pt.grp),
        .i_key   (i_key),
        .i_clear (w_clear),
        .o_busy  (w_fr_busy),
        .o_emit  (w_fr_emit),
        .o_ovf   (w_fr_ovf)
    );

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= (w_kind == crgd_pkg::KIND_END) ? '0 : {r_pt.z, r_pt.y, r_pt.x};
            r_tuser <= {w_ovf, w_kind};
            r_tlast <= w_pend_nx == '0;
        end
        if (w_pop) begin
            r_pt <= i_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_tvalid <= 1'b0;
            r_pend   <= '0;
        end else begin
            if (w_load) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (w_pop) begin
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (!w_busy) begin
                        r_pend   <= {r_pt.last,
                                     r_pt.fr & (!r_pt.grp | w_fr_emit),
                                     r_pt.ob & (!r_pt.grp | w_ob_emit)};
                        r_ovf_ob <= r_pt.grp & w_ob_ovf;
                        r_ovf_fr <= r_pt.grp & w_fr_ovf;
                        r_state  <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (r_pend == '0) begin
                        r_state <= B_IDLE;
                    end else if (w_load) begin
                        r_pend <= w_pend_nx;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/class_range_grid_dedup.sv */
// flow: accept, a restoring divide when grouping is on, hand-off through the queue, then
// a table probe that reads and compares one slot after another, then one result at a time
// the front holds one point at a time and takes no new point until it is handed on; the
// back likewise takes one point at a time and waits for its probes and results
// reset: control cleared at once; each seen-cell table then runs a clearing pass over all
// CELLS_PER_CLASS slots, and the same pass follows every end-of-frame marker
`default_nettype none
module class_range_grid_dedup #(
    parameter int CELLS_PER_CLASS = crgd_pkg::CELLS_PER_CLASS_DEF,
    parameter int INDEX_BITS      = crgd_pkg::INDEX_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // input points
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [127:0] i_s_tdata,   // pos_x, pos_y, pos_z, ray_depth
    input  wire  [1:0]   i_s_tuser,   // obstacle_hit, free_hit
    input  wire          i_s_tlast,   // frame_last
    // results
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [95:0]  o_m_tdata,   // out_x, out_y, out_z
    output logic [2:0]   o_m_tuser,   // kind (2 bits), overflow
    output logic         o_m_tlast,   // last_of_item
    // configuration writes
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_idx,
    input  wire  [31:0]  i_cfg_data
);

    localparam int DW  = crgd_pkg::DATA_W;
    localparam int PTW = $bits(crgd_pkg::t_pt);
    localparam int QW  = PTW + 2 * INDEX_BITS;

    logic [crgd_pkg::CELL_W-1:0] r_cell;
    logic [DW-1:0]               r_ob_range;
    logic [DW-1:0]               r_fr_range;

    // front to queue
    logic                    w_f_valid, w_f_ready;
    crgd_pkg::t_pt           w_f_pt;
    logic [2*INDEX_BITS-1:0] w_f_key;
    // queue to back
    logic                    w_q_valid, w_q_ready;
    logic [QW-1:0]           w_q_data;
    crgd_pkg::t_pt           w_q_pt;

    // register file, to be written only while the block is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell     <= crgd_pkg::CELL_SIZE_RST;
            r_ob_range <= crgd_pkg::OBSTACLE_RANGE_RST;
            r_fr_range <= crgd_pkg::FREE_RANGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crgd_pkg::CFG_CELL_SIZE:      r_cell     <= i_cfg_data[crgd_pkg::CELL_W-1:0];
                crgd_pkg::CFG_OBSTACLE_RANGE: r_ob_range <= i_cfg_data;
                crgd_pkg::CFG_FREE_RANGE:     r_fr_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: range check, class routing and the cell index divider
    crgd_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_x        (i_s_tdata[31:0]),
        .i_y        (i_s_tdata[63:32]),
        .i_z        (i_s_tdata[95:64]),
        .i_depth    (i_s_tdata[127:96]),
        .i_ob       (i_s_tuser[0]),
        .i_fr       (i_s_tuser[1]),
        .i_last     (i_s_tlast),
        .i_cell     (r_cell),
        .i_ob_range (r_ob_range),
        .i_fr_range (r_fr_range),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_pt       (w_f_pt),
        .o_key      (w_f_key)
    );

    // short queue decouples division from table probing
    crgd_fifo #(.WIDTH(QW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (w_f_valid),
        .o_wready (w_f_ready),
        .i_wdata  ({w_f_key, w_f_pt}),
        .o_rvalid (w_q_valid),
        .i_rready (w_q_ready),
        .o_rdata  (w_q_data)
    );

    assign w_q_pt = crgd_pkg::t_pt'(w_q_data[PTW-1:0]);

    // back: per class seen-cell tables and the result register
    crgd_back #(
        .CELLS_PER_CLASS (CELLS_PER_CLASS),
        .INDEX_BITS      (INDEX_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_pt     (w_q_pt),
        .i_key    (w_q_data[QW-1:PTW]),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

/* sim/class_range_grid_dedup_tb.sv */
`default_nettype none
module class_range_grid_dedup_tb;

    localparam int TABLE_CELLS = 4096;
    localparam int IDX_W       = 24;
    localparam longint IDX_HI  = (longint'(1) <<< (IDX_W - 1)) - 1;
    localparam longint IDX_LO  = -IDX_HI - 1;
    // clearing pass after a frame end plus some slack
    localparam int SETTLE_CYCLES = TABLE_CELLS + 300;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        depth;
        logic               ob;
        logic               fr;
        logic               last;
        logic               hold;   // wait for all results before sending
    } t_point;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ovf;
        logic               last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         o_m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_idx = '0;
    logic [31:0]  cfg_data = '0;

    class_range_grid_dedup uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),     // pos_x, pos_y, pos_z, ray_depth
        .i_s_tuser  (s_tuser),     // obstacle_hit, free_hit
        .i_s_tlast  (s_tlast),     // frame_last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),   // out_x, out_y, out_z
        .o_m_tuser  (o_m_tuser),   // kind (2 bits), overflow
        .o_m_tlast  (o_m_tlast),   // last_of_item
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and seen-cell tables
    logic [19:0] cell_sz;
    logic [31:0] obst_range;
    logic [31:0] free_range;
    logic [47:0] seen_key [2][TABLE_CELLS];
    int          seen_cnt [2];

    t_point  pending_points[$];
    t_result expected_results[$];
    int      errors = 0;
    int      idle_send = 0;
    int      idle_recv = 0;

    function automatic void add_point(t_point p);
        pending_points = {pending_points, p};
    endfunction

    function automatic void add_result(t_result r);
        expected_results = {expected_results, r};
    endfunction

    // floor(pos / cell), saturated to the signed index range
    function automatic logic [IDX_W-1:0] grid_index(logic signed [31:0] p, logic [19:0] c);
        longint pv;
        longint cv;
        longint q;
        pv = p;
        cv = c;
        q = pv / cv;
        if ((pv % cv) != 0 && pv < 0) q = q - 1;
        if (q > IDX_HI) q = IDX_HI;
        if (q < IDX_LO) q = IDX_LO;
        return q[IDX_W-1:0];
    endfunction

    task automatic predict_point(t_point p);
        logic [47:0] key;
        logic        hit;
        logic [31:0] rng;
        logic        dup;
        logic        ovf;
        t_result     r;
        int          n;
        key = '0;
        n = 0;
        if (cell_sz != 0) key = {grid_index(p.x, cell_sz), grid_index(p.y, cell_sz)};
        for (int c = 0; c < 2; c++) begin
            hit = (c == 0) ? p.ob : p.fr;
            rng = (c == 0) ? obst_range : free_range;
            if (hit && p.depth <= rng) begin
                dup = 1'b0;
                ovf = 1'b0;
                if (cell_sz != 0) begin
                    for (int i = 0; i < seen_cnt[c]; i++)
                        if (seen_key[c][i] == key) dup = 1'b1;
                    if (!dup) begin
                        if (seen_cnt[c] >= TABLE_CELLS) begin
                            ovf = 1'b1;
                        end else begin
                            seen_key[c][seen_cnt[c]] = key;
                            seen_cnt[c]++;
                        end
                    end
                end
                if (!dup) begin
                    r.kind = (c == 0) ? crgd_pkg::KIND_OBST : crgd_pkg::KIND_FREE;
                    r.x = p.x;
                    r.y = p.y;
                    r.z = p.z;
                    r.ovf = ovf;
                    r.last = 1'b0;
                    add_result(r);
                    n++;
                end
            end
        end
        if (p.last) begin
            r = '0;
            r.kind = crgd_pkg::KIND_END;
            add_result(r);
            n++;
            seen_cnt[0] = 0;
            seen_cnt[1] = 0;
        end
        // mark the final result of this item
        if (n > 0) expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    // driver: one item on the input stream, held until accepted
    always @(posedge i_clk) begin
        t_point p;
        logic   go;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !o_s_tready)) begin
            go = pending_points.size() > 0 && $urandom_range(99) >= idle_send;
            if (go && pending_points[0].hold && (s_tvalid || expected_results.size() > 0))
                go = 1'b0;
            if (go) begin
                p = pending_points.pop_front();
                s_tdata  <= {p.depth, p.z, p.y, p.x};
                s_tuser  <= {p.fr, p.ob};
                s_tlast  <= p.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_tready <= i_rst_n && ($urandom_range(99) >= idle_recv);
    end

    // checker first, then prediction of the item taken at this edge
    always @(posedge i_clk) begin
        t_result e;
        t_point  p;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind %0d", o_m_tuser[1:0]);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_m_tuser[1:0] !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_m_tuser[1:0]); errors++;
                end
                if (o_m_tdata[31:0] !== e.x) begin
                    $error("out_x exp %h got %h", e.x, o_m_tdata[31:0]); errors++;
                end
                if (o_m_tdata[63:32] !== e.y) begin
                    $error("out_y exp %h got %h", e.y, o_m_tdata[63:32]); errors++;
                end
                if (o_m_tdata[95:64] !== e.z) begin
                    $error("out_z exp %h got %h", e.z, o_m_tdata[95:64]); errors++;
                end
                if (o_m_tuser[2] !== e.ovf) begin
                    $error("overflow exp %0d got %0d", e.ovf, o_m_tuser[2]); errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last_of_item exp %0d got %0d", e.last, o_m_tlast); errors++;
                end
            end
        end
        if (i_rst_n && s_tvalid && o_s_tready) begin
            p.x = s_tdata[31:0];
            p.y = s_tdata[63:32];
            p.z = s_tdata[95:64];
            p.depth = s_tdata[127:96];
            p.ob = s_tuser[0];
            p.fr = s_tuser[1];
            p.last = s_tlast;
            p.hold = 1'b0;
            predict_point(p);
        end
    end

    function automatic t_point mk(logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic [31:0] d,
                                  logic ob, logic fr, logic last);
        t_point p;
        p.x = x; p.y = y; p.z = z; p.depth = d;
        p.ob = ob; p.fr = fr; p.last = last; p.hold = 1'b0;
        return p;
    endfunction

    // mostly clustered points so cells repeat, sometimes full-range values
    function automatic t_point rand_point();
        t_point p;
        p.x = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8*65536) - 4*65536;
        p.y = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8*65536) - 4*65536;
        p.z = $urandom;
        p.depth = ($urandom_range(4) == 0) ? $urandom : $urandom_range(12*65536);
        p.ob = $urandom_range(1);
        p.fr = $urandom_range(1);
        p.last = ($urandom_range(7) == 0);
        p.hold = 1'b0;
        return p;
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_points.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            crgd_pkg::CFG_CELL_SIZE:      cell_sz = val[19:0];
            crgd_pkg::CFG_OBSTACLE_RANGE: obst_range = val;
            crgd_pkg::CFG_FREE_RANGE:     free_range = val;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int mode, int count);
        t_point p;
        case (mode)
            0: begin idle_send = 0;  idle_recv = 0;  end
            1: begin idle_send = 88; idle_recv = 0;  end
            2: begin idle_send = 0;  idle_recv = 88; end
            default: begin idle_send = 8; idle_recv = 8; end
        endcase
        for (int i = 0; i < count; i++) begin
            p = rand_point();
            if (i == count / 2) p.hold = 1'b1;
            add_point(p);
        end
        wait_idle();
    endtask

    initial begin
        t_point p;
        cell_sz    = crgd_pkg::CELL_SIZE_RST;
        obst_range = crgd_pkg::OBSTACLE_RANGE_RST;
        free_range = crgd_pkg::FREE_RANGE_RST;
        seen_cnt[0] = 0;
        seen_cnt[1] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // directed points at reset settings
        add_point(mk(0, 0, 32'sh7fffffff, 0, 1, 0, 0));     // obstacle, new cell
        add_point(mk(100, 50, 1, 0, 1, 0, 0));              // same cell, dropped
        add_point(mk(0, 0, 32'sh80000000, 655360, 0, 1, 0));// free at range edge
        add_point(mk(5*9830, 0, 3, 196608, 1, 1, 0));       // both classes
        add_point(mk(7*9830, 0, 4, 196609, 1, 1, 0));       // past obstacle range
        add_point(mk(9*9830, 0, 5, 655361, 1, 1, 0));       // past both ranges
        add_point(mk(11*9830, 0, 6, 0, 0, 0, 0));           // no route
        add_point(mk(-1, -1, 7, 0, 1, 1, 0));               // negative floor
        add_point(mk(-9830, -9830, 8, 0, 1, 1, 0));         // same cell -1
        add_point(mk(-9831, -1, 9, 0, 1, 1, 0));            // cell -2
        add_point(mk(32'sh7fffffff, 32'sh80000000, 10, 0, 1, 1, 0));
        add_point(mk(32'sh80000000, 32'sh7fffffff, 11, 32'hffffffff, 1, 1, 0));
        add_point(mk(1, 1, 12, 0, 0, 0, 1));                // marker only
        add_point(mk(0, 0, 13, 0, 1, 1, 0));                // table cleared
        p = mk(0, 0, 14, 0, 1, 1, 1);                       // cell already seen: end marker only
        p.hold = 1'b1;
        add_point(p);
        add_point(mk(0, 0, 15, 0, 1, 1, 0));
        wait_idle();

        // grouping off, widest ranges
        write_reg(crgd_pkg::CFG_CELL_SIZE, 32'd0);
        write_reg(crgd_pkg::CFG_OBSTACLE_RANGE, 32'hffffffff);
        write_reg(crgd_pkg::CFG_FREE_RANGE, 32'hffffffff);
        random_phase(0, 26);

        // smallest cell saturates indexes, zero obstacle range
        write_reg(crgd_pkg::CFG_CELL_SIZE, 32'd1);
        write_reg(crgd_pkg::CFG_OBSTACLE_RANGE, 32'd0);
        write_reg(crgd_pkg::CFG_FREE_RANGE, 32'h00060000);
        random_phase(1, 26);

        // largest cell used here, cells repeat a lot
        write_reg(crgd_pkg::CFG_CELL_SIZE, 32'd655360);
        write_reg(crgd_pkg::CFG_OBSTACLE_RANGE, 32'h00080000);
        write_reg(crgd_pkg::CFG_FREE_RANGE, 32'd0);
        random_phase(2, 26);

        write_reg(crgd_pkg::CFG_CELL_SIZE, $urandom_range(655360, 1));
        write_reg(crgd_pkg::CFG_OBSTACLE_RANGE, $urandom_range(12*65536));
        write_reg(crgd_pkg::CFG_FREE_RANGE, $urandom_range(12*65536));
        random_phase(3, 26);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("class_range_grid_dedup_tb OK");
        end else begin
            $display("class_range_grid_dedup_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #(20 * 3000000);
        $display("class_range_grid_dedup_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/crgd_pkg.sv
rtl/core/crgd_front.sv
rtl/core/crgd_fifo.sv
rtl/core/crgd_table.sv
rtl/core/crgd_back.sv
rtl/core/class_range_grid_dedup.sv
sim/class_range_grid_dedup_tb.sv
